@@ src/iscn_pkg.sv @@
// Package for the IMU sample calibrate/normalize block.
// Pipeline stage numbers, fixed-point constants and register index codes.
// No dependencies.
package iscn_pkg;

   // total registered stages from request accept to result register
   localparam int LAT           = 49;
   localparam int TEMP_OUT_STG  = 3;
   localparam int GYRO_OUT_STG  = 6;

   localparam logic [59:0] ACC_SCALE_RESET = 60'h040000400004_0000;

   // temperature: q = (|raw|*1280 + 817) / 1634, then +/- q + 6400
   // divide done as x * ceil(2^37/1634) >> 37, exact for x < 2^26
   localparam logic [10:0] TEMP_MUL   = 11'd1280;
   localparam logic [9:0]  TEMP_BIAS  = 10'd817;
   localparam logic [26:0] TEMP_RECIP = 27'd84111967;
   localparam logic [15:0] TEMP_OFS   = 16'd6400;

   // gyro: q = ((|raw| * 25*PI32) << range + 9*2^31) / (9*2^32)
   // divide by 9 done as z * ceil(2^28/9) >> 28, exact for z < 2^25
   localparam logic [38:0] GYRO_C     = 39'd337325942625;
   localparam logic [57:0] GYRO_RND   = 58'd19327352832;
   localparam logic [24:0] GYRO_RECIP = 25'd29826162;

   typedef enum logic [1:0] {
      CSR_ACCEL_OFFSETS,
      CSR_ACCEL_SCALES,
      CSR_GYRO_OFFSETS,
      CSR_GYRO_RANGE
   } csr_index_type;

endpackage

@@ src/iscn_accel.sv @@
// Accel path: offset, scale, block normalize, pipelined square root and
// per-axis restoring divide to a Q1.14 unit vector. Uses iscn_pkg.
// Pipeline of iscn_pkg::LAT registered stages, each advanced by adv.
module iscn_accel (
   input  logic             clock,
   input  logic             adv,
   input  logic [2:0][15:0] raw,
   input  logic [59:0]      offsets,
   input  logic [59:0]      scales,
   output logic [2:0][15:0] unit,
   output logic             zero
);

   localparam int L = iscn_pkg::LAT;

   logic signed [20:0] d_in [3];
   logic [2:0][20:0]   dabs_in;
   logic [2:0]         dneg_in;
   logic [2:0][20:0]   dabs_ff;

   logic [2:0][39:0]   mag2_ff, mag3_ff, mag4_ff;
   logic [39:0]        max_in, max3_ff;
   logic [5:0]         p_in, p4_ff;
   logic [2:0][23:0]   sh_in;
   logic [2:0][23:0]   sh_ff [5:32];
   logic [2:0][47:0]   sq6_ff;
   logic [49:0]        s7_ff;
   logic [49:0]        s_ff [8:32];
   logic [50:0]        res_ff [8:32];
   logic [2:0][38:0]   num33_ff;
   logic [25:0]        n_ff [33:L-1];
   logic [2:0][38:0]   rem_ff [34:L-1];
   logic [2:0][14:0]   q_ff [34:L-1];
   logic [2:0]         neg_ff [1:L-1];
   logic               zero_ff [4:L-1];
   logic [2:0][15:0]   unit_ff;
   logic               zero_out_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k] = $signed({raw[k][15], raw[k], 4'b0000})
                 - $signed({offsets[20*k+19], offsets[20*k +: 20]});
         dneg_in[k] = d_in[k][20];
         dabs_in[k] = d_in[k][20] ? 21'(-d_in[k]) : 21'(d_in[k]);
      end
   end

   always_comb begin
      max_in = mag2_ff[0];
      if (mag2_ff[1] > max_in) max_in = mag2_ff[1];
      if (mag2_ff[2] > max_in) max_in = mag2_ff[2];
   end

   always_comb begin
      p_in = '0;
      for (int b = 0; b < 40; b++) begin
         if (max3_ff[b]) p_in = 6'(b);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (p4_ff > 6'd23) sh_in[k] = 24'(mag4_ff[k] >> (p4_ff - 6'd23));
         else sh_in[k] = 24'(mag4_ff[k] << (6'd23 - p4_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dabs_ff   <= dabs_in;
         neg_ff[1] <= dneg_in;
         for (int s = 2; s < L; s++) neg_ff[s] <= neg_ff[s-1];
         for (int k = 0; k < 3; k++) begin
            mag2_ff[k] <= 40'(dabs_ff[k] * scales[20*k +: 20]);
            sq6_ff[k]  <= sh_ff[5][k] * sh_ff[5][k];
         end
         mag3_ff    <= mag2_ff;
         max3_ff    <= max_in;
         mag4_ff    <= mag3_ff;
         p4_ff      <= p_in;
         zero_ff[4] <= (max3_ff == '0);
         for (int s = 5; s < L; s++) zero_ff[s] <= zero_ff[s-1];
         sh_ff[5] <= sh_in;
         for (int s = 6; s <= 32; s++) sh_ff[s] <= sh_ff[s-1];
         s7_ff <= 50'(sq6_ff[0]) + 50'(sq6_ff[1]) + 50'(sq6_ff[2]);
         n_ff[33] <= res_ff[32][25:0];
         for (int s = 34; s < L; s++) n_ff[s] <= n_ff[s-1];
         for (int k = 0; k < 3; k++) begin
            num33_ff[k] <= {1'b0, sh_ff[32][k], 14'b0} + 39'(res_ff[32][25:1]);
         end
      end
   end

   for (genvar t = 8; t <= 32; t++) begin : g_sqrt
      localparam logic [50:0] BIT = 51'(1) << (2 * (32 - t));
      logic [49:0] s_prev;
      logic [50:0] res_prev;
      logic [50:0] trial;
      logic        take;
      if (t == 8) begin : g_first
         assign s_prev   = s7_ff;
         assign res_prev = '0;
      end else begin : g_next
         assign s_prev   = s_ff[t-1];
         assign res_prev = res_ff[t-1];
      end
      assign trial = res_prev + BIT;
      assign take  = {1'b0, s_prev} >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            s_ff[t]   <= take ? 50'({1'b0, s_prev} - trial) : s_prev;
            res_ff[t] <= take ? (res_prev >> 1) + BIT : (res_prev >> 1);
         end
      end
   end

   for (genvar t = 34; t < L; t++) begin : g_div
      localparam int SH = L - 1 - t;
      logic [2:0][38:0] rem_prev;
      logic [2:0][14:0] q_prev;
      logic [2:0][40:0] dvs;
      logic [2:0]       take;
      if (t == 34) begin : g_first
         assign rem_prev = num33_ff;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[t-1];
         assign q_prev   = q_ff[t-1];
      end
      for (genvar k = 0; k < 3; k++) begin : g_lane
         assign dvs[k]  = 41'(n_ff[t-1]) << SH;
         assign take[k] = {2'b00, rem_prev[k]} >= dvs[k];
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[t][k] <= take[k] ? 39'({2'b00, rem_prev[k]} - dvs[k]) : rem_prev[k];
               q_ff[t][k]   <= q_prev[k] | (take[k] ? (15'(1) << SH) : 15'(0));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_out_ff <= zero_ff[L-1];
         for (int k = 0; k < 3; k++) begin
            if (zero_ff[L-1]) unit_ff[k] <= '0;
            else if (neg_ff[L-1][k]) begin
               unit_ff[k] <= (q_ff[L-1][k] > 15'd16384) ? -16'sd16384
                                                        : 16'(-{1'b0, q_ff[L-1][k]});
            end else begin
               unit_ff[k] <= (q_ff[L-1][k] > 15'd16384) ? 16'd16384 : {1'b0, q_ff[L-1][k]};
            end
         end
      end
   end

   assign unit = unit_ff;
   assign zero = zero_out_ff;

endmodule

@@ src/imu_sample_calibrate_normalize.sv @@
// Top level of the IMU sample calibrate/normalize block: request/result
// streams, register file, temperature and gyro paths. Uses iscn_pkg and
// iscn_accel.
//
//   channel   dir  handshake              payload
//   req       in   req_tvalid/req_tready   req_tdata  (7 x 16-bit raw words)
//   rsp       out  rsp_tvalid/rsp_tready   rsp_tdata, rsp_tuser (accel_zero)
//   csr       in   csr_we                  csr_addr, csr_wdata
//
// One request per cycle while the output is not stalled; the pipeline
// depth is set by the accel square root and divide stages.
// A stalled result freezes the whole pipeline; req_tready drops only then.
// Synchronous reset clears the valid pipeline and resets the registers.
module imu_sample_calibrate_normalize (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // accel_x, accel_y, accel_z, temp, gyro_x, gyro_y, gyro_z (16b each)
   input  logic [111:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // unit_x, unit_y, unit_z, temp_celsius (16b each), gyro_rate_x/y/z (24b)
   output logic [135:0]  rsp_tdata,
   // accel_zero
   output logic          rsp_tuser,
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic [59:0]   csr_wdata
);

   localparam int L  = iscn_pkg::LAT;
   localparam int TS = iscn_pkg::TEMP_OUT_STG;
   localparam int GS = iscn_pkg::GYRO_OUT_STG;

   logic [59:0] acc_off_ff, acc_scl_ff, gyr_off_ff;
   logic [1:0]  gyr_rng_ff;
   logic [L-1:0] vld_ff;
   logic        adv;

   logic [2:0][15:0] unit;
   logic             zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_off_ff <= '0;
         acc_scl_ff <= iscn_pkg::ACC_SCALE_RESET;
         gyr_off_ff <= '0;
         gyr_rng_ff <= '0;
      end else if (csr_we) begin
         unique case (iscn_pkg::csr_index_type'(csr_addr))
            iscn_pkg::CSR_ACCEL_OFFSETS: acc_off_ff <= csr_wdata;
            iscn_pkg::CSR_ACCEL_SCALES:  acc_scl_ff <= csr_wdata;
            iscn_pkg::CSR_GYRO_OFFSETS:  gyr_off_ff <= csr_wdata;
            iscn_pkg::CSR_GYRO_RANGE:    gyr_rng_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign adv        = ~vld_ff[L-1] | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[L-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[L-2:0], req_tvalid};
   end

   iscn_accel u_accel (
      .clock   (clock),
      .adv     (adv),
      .raw     (req_tdata[47:0]),
      .offsets (acc_off_ff),
      .scales  (acc_scl_ff),
      .unit    (unit),
      .zero    (zero)
   );

   // temperature
   logic [15:0] traw;
   logic [15:0] tabs_in;
   logic [25:0] tx_ff;
   logic [51:0] tp_ff;
   logic        tneg_ff [1:TS-1];
   logic [14:0] tq;
   logic [15:0] tval_in;
   logic [15:0] t_dly_ff [0:L-TS];

   assign traw    = req_tdata[63:48];
   assign tabs_in = traw[15] ? 16'(-traw) : traw;
   assign tq      = tp_ff[51:37];

   assign tval_in = (tneg_ff[TS-1] ? 16'(-{1'b0, tq}) : {1'b0, tq})
                  + iscn_pkg::TEMP_OFS;

   always_ff @(posedge clock) begin
      if (adv) begin
         tx_ff      <= 26'(tabs_in * iscn_pkg::TEMP_MUL) + 26'(iscn_pkg::TEMP_BIAS);
         tp_ff      <= 52'(tx_ff * iscn_pkg::TEMP_RECIP);
         tneg_ff[1] <= traw[15];
         for (int s = 2; s < TS; s++) tneg_ff[s] <= tneg_ff[s-1];
         t_dly_ff[0] <= tval_in;
         for (int s = 1; s <= L - TS; s++) t_dly_ff[s] <= t_dly_ff[s-1];
      end
   end

   // gyro
   logic [2:0][15:0] graw;
   logic [2:0][15:0] gabs_in;
   logic [2:0][15:0] gabs_ff;
   logic [2:0][35:0] gpl_ff;
   logic [2:0][34:0] gph_ff;
   logic [2:0][54:0] gx_ff;
   logic [2:0][57:0] gy_in;
   logic [2:0][24:0] gz_ff;
   logic [2:0][49:0] gp_ff;
   logic [2:0]       gneg_ff [1:GS-1];
   logic [2:0][23:0] grate_in;
   logic [2:0][23:0] g_dly_ff [0:L-GS];

   assign graw = req_tdata[111:64];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         gabs_in[k]  = graw[k][15] ? 16'(-graw[k]) : graw[k];
         gy_in[k]    = (58'(gx_ff[k]) << gyr_rng_ff) + iscn_pkg::GYRO_RND;
         grate_in[k] = (gneg_ff[GS-1][k] ? 24'(-{2'b00, gp_ff[k][49:28]})
                                         : {2'b00, gp_ff[k][49:28]})
                     - {{4{gyr_off_ff[20*k+19]}}, gyr_off_ff[20*k +: 20]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gabs_ff    <= gabs_in;
         gneg_ff[1] <= {graw[2][15], graw[1][15], graw[0][15]};
         for (int s = 2; s < GS; s++) gneg_ff[s] <= gneg_ff[s-1];
         for (int k = 0; k < 3; k++) begin
            gpl_ff[k] <= gabs_ff[k] * iscn_pkg::GYRO_C[19:0];
            gph_ff[k] <= gabs_ff[k] * iscn_pkg::GYRO_C[38:20];
            gx_ff[k]  <= {gph_ff[k], 20'b0} + 55'(gpl_ff[k]);
            gz_ff[k]  <= gy_in[k][56:32];
            gp_ff[k]  <= 50'(gz_ff[k] * iscn_pkg::GYRO_RECIP);
         end
         g_dly_ff[0] <= grate_in;
         for (int s = 1; s <= L - GS; s++) g_dly_ff[s] <= g_dly_ff[s-1];
      end
   end

   assign rsp_tdata = {g_dly_ff[L-GS][2], g_dly_ff[L-GS][1], g_dly_ff[L-GS][0],
                       t_dly_ff[L-TS], unit[2], unit[1], unit[0]};
   assign rsp_tuser = zero;

   a_zero_units: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[47:0] == '0)
      else $error("zero accel vector with nonzero unit outputs");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd16384 &&
                      $signed(rsp_tdata[15:0]) >= -16'sd16384))
      else $error("unit x out of range");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[63:48]) <= 16'sd32070 &&
                      $signed(rsp_tdata[63:48]) >= -16'sd19270))
      else $error("temperature out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

endmodule

@@ dv/imu_sample_calibrate_normalize_tb.sv @@
// Self-checking testbench for imu_sample_calibrate_normalize.
// Clocked driver and monitor, predictor of the calibration math, scoreboard.
// Depends on iscn_pkg and the block's RTL.
`timescale 1ns / 100ps

module imu_sample_calibrate_normalize_tb;

   typedef struct packed {
      logic [15:0] gz, gy, gx, temp, az, ay, ax;
   } sample_type;

   typedef struct packed {
      logic        zero;
      logic [23:0] gz, gy, gx;
      logic [15:0] temp, uz, uy, ux;
   } cal_type;

   localparam longint unsigned PI_Q32 = 64'd13493037705;
   localparam int TIMEOUT = 400000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [135:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_addr = '0;
   logic [59:0]   csr_wdata = '0;

   logic [59:0] acc_ofs_q, acc_scl_q, gyr_ofs_q;
   logic [1:0]  gyr_rng_q;

   sample_type pending_samples[$];
   cal_type    expected_cal[$];
   int      mismatches = 0;
   int      cycles = 0;
   bit      calm = 1'b0;
   bit      hold_trigger = 1'b0, hold_done = 1'b0;
   int      hold_left = 0;

   imu_sample_calibrate_normalize dut (.*);

   always #6 clock = ~clock;

   function automatic longint unsigned isqrt(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 50;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic cal_type calibrate(sample_type s);
      cal_type         c;
      logic [15:0]     acc[3];
      logic [15:0]     gyr[3];
      longint          a, num, rate;
      longint unsigned mag[3], maxm, sum, n, u, m, q, den;
      bit              neg[3];
      int              p;
      acc[0] = s.ax; acc[1] = s.ay; acc[2] = s.az;
      gyr[0] = s.gx; gyr[1] = s.gy; gyr[2] = s.gz;
      maxm = 0;
      for (int k = 0; k < 3; k++) begin
         a = (longint'($signed(acc[k])) * 16 - longint'($signed(acc_ofs_q[20*k +: 20])))
             * longint'({1'b0, acc_scl_q[20*k +: 20]});
         neg[k] = a < 0;
         mag[k] = neg[k] ? -a : a;
         if (mag[k] > maxm) maxm = mag[k];
      end
      c = '0;
      if (maxm == 0) begin
         c.zero = 1'b1;
      end else begin
         p = 0;
         sum = 0;
         while ((maxm >> p) > 1) p++;
         for (int k = 0; k < 3; k++) begin
            if (p > 23) mag[k] >>= (p - 23);
            else mag[k] <<= (23 - p);
            sum += mag[k] * mag[k];
         end
         n = isqrt(sum);
         for (int k = 0; k < 3; k++) begin
            u = ((mag[k] << 14) + (n >> 1)) / n;
            if (u > 16384) u = 16384;
            u = neg[k] ? -u : u;
            if (k == 0) c.ux = u[15:0];
            else if (k == 1) c.uy = u[15:0];
            else c.uz = u[15:0];
         end
      end
      num = longint'($signed(s.temp)) * 640;
      m = num < 0 ? -num : num;
      q = (2 * m + 817) / 1634;
      num = (num < 0 ? -longint'(q) : longint'(q)) + 6400;
      c.temp = num[15:0];
      den = 64'd90 << 32;
      for (int k = 0; k < 3; k++) begin
         num = longint'($signed(gyr[k])) * (longint'(250) << gyr_rng_q);
         m = num < 0 ? -num : num;
         q = (m * PI_Q32 + (den >> 1)) / den;
         rate = (num < 0 ? -longint'(q) : longint'(q))
                - longint'($signed(gyr_ofs_q[20*k +: 20]));
         if (k == 0) c.gx = rate[23:0];
         else if (k == 1) c.gy = rate[23:0];
         else c.gz = rate[23:0];
      end
      return c;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_cal.push_back(calibrate(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
               req_tdata <= pending_samples.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_trigger && !hold_done) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      cal_type e, r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            r = {rsp_tuser, rsp_tdata};
            if (expected_cal.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", r);
            end else begin
               e = expected_cal.pop_front();
               check_field("unit_x", e.ux, r.ux);
               check_field("unit_y", e.uy, r.uy);
               check_field("unit_z", e.uz, r.uz);
               check_field("accel_zero", e.zero, r.zero);
               check_field("temp", e.temp, r.temp);
               check_field("rate_x", e.gx, r.gx);
               check_field("rate_y", e.gy, r.gy);
               check_field("rate_z", e.gz, r.gz);
            end
         end
         rsp_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 30);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic csr_write(iscn_pkg::csr_index_type idx, logic [59:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         iscn_pkg::CSR_ACCEL_OFFSETS: acc_ofs_q = val;
         iscn_pkg::CSR_ACCEL_SCALES:  acc_scl_q = val;
         iscn_pkg::CSR_GYRO_OFFSETS:  gyr_ofs_q = val;
         iscn_pkg::CSR_GYRO_RANGE:    gyr_rng_q = val[1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sampled at the falling edge so that edge updates have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || expected_cal.size() != 0 || req_tvalid);
   endtask

   task automatic push(logic [15:0] ax, ay, az, t, gx, gy, gz);
      @(negedge clock);
      pending_samples.push_back({gz, gy, gx, t, az, ay, ax});
   endtask

   function automatic logic [15:0] rnd_word();
      case ($urandom_range(5))
         0: return 16'($urandom_range(31) - 16);
         1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [59:0] rnd_reg();
      return 60'({$urandom, $urandom});
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0)
            push(0, 0, 0, rnd_word(), rnd_word(), rnd_word(), rnd_word());
         else
            push(rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                 rnd_word(), rnd_word(), rnd_word());
      end
   endtask

   initial begin
      acc_ofs_q = '0;
      acc_scl_q = iscn_pkg::ACC_SCALE_RESET;
      gyr_ofs_q = '0;
      gyr_rng_q = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings
      push(0, 0, 0, 0, 0, 0, 0);
      push(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      push(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      push(1, 0, 0, 16'hffff, 1, 16'hffff, 0);
      push(0, 16'hffff, 0, 163, 16'h8000, 16'h7fff, 1);
      push(0, 0, 16'h8000, 16'hff5d, 100, 16'hff9c, 2);
      push(3, 4, 0, 327, 16'h1234, 16'hedcc, 0);
      push(16'h7fff, 1, 16'h8000, 16'h0100, 16'h4000, 16'hc000, 16'h0001);
      wait_idle();
      csr_write(iscn_pkg::CSR_GYRO_RANGE, 3);
      csr_write(iscn_pkg::CSR_ACCEL_OFFSETS, 60'h80000_7ffff_80000);
      csr_write(iscn_pkg::CSR_ACCEL_SCALES, 60'hfffff_fffff_fffff);
      csr_write(iscn_pkg::CSR_GYRO_OFFSETS, 60'h7ffff_80000_7ffff);
      push(16'h7fff, 16'h8000, 16'h7fff, 0, 16'h7fff, 16'h8000, 16'h7fff);
      push(16'h8000, 16'h7fff, 16'h8000, 0, 16'h8000, 16'h7fff, 16'h8000);
      push(0, 0, 0, 0, 0, 0, 0);
      push(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      wait_idle();
      csr_write(iscn_pkg::CSR_ACCEL_SCALES, 60'h00000_00000_00000);
      csr_write(iscn_pkg::CSR_GYRO_RANGE, 1);
      push(16'h1234, 16'h8000, 16'h7fff, 16'h8000, 5, 16'hfffb, 0);
      wait_idle();
      csr_write(iscn_pkg::CSR_ACCEL_SCALES, 60'h00000_00000_40000);
      csr_write(iscn_pkg::CSR_ACCEL_OFFSETS, 60'h00010_00000_00010);
      csr_write(iscn_pkg::CSR_GYRO_RANGE, 2);
      push(1, 0, 1, 0, 0, 0, 0);
      push(16'h7fff, 1, 0, 16'h8000, 16'h8000, 0, 16'h7fff);
      wait_idle();

      // random, full pipeline with a long receiver stall
      csr_write(iscn_pkg::CSR_ACCEL_OFFSETS, '0);
      csr_write(iscn_pkg::CSR_ACCEL_SCALES, iscn_pkg::ACC_SCALE_RESET);
      csr_write(iscn_pkg::CSR_GYRO_RANGE, 0);
      calm = 1'b1;
      hold_trigger = 1'b1;
      random_phase(130);
      wait_idle();
      calm = 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(iscn_pkg::CSR_ACCEL_OFFSETS,
                   ph[0] ? rnd_reg() : (rnd_reg() & 60'h00fff_00fff_00fff));
         csr_write(iscn_pkg::CSR_ACCEL_SCALES, rnd_reg());
         csr_write(iscn_pkg::CSR_GYRO_OFFSETS, rnd_reg());
         csr_write(iscn_pkg::CSR_GYRO_RANGE, 60'(ph[1:0] ^ 2'd1));
         random_phase(130);
         wait_idle();
      end

      repeat (60) @(posedge clock);
      if (mismatches == 0 && expected_cal.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
